// ===== rtl/core/pdusbp_pkg.sv =====
// shared types and constants of the signal bit packer
package pdusbp_pkg;

  localparam int unsigned FRAME_BYTES = 64;
  localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);

  localparam int unsigned POS_W   = 9;
  localparam int unsigned SIZE_W  = 7;
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned BIDX_W  = 6;
  localparam int unsigned OFF_W   = 3;
  localparam int unsigned BASE_W  = POS_W - OFF_W;
  localparam int unsigned SPAN_W  = VAL_W + BYTE_W;
  localparam int unsigned NB_W    = 4;
  localparam int unsigned CALC_W  = 10;

  localparam logic [SIZE_W-1:0] MAX_SIZE = 7'd64;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [POS_W-1:0]  bit_position;
    logic [SIZE_W-1:0] bit_size;
    logic              big_endian;
    logic [VAL_W-1:0]  signal_value;
  } sig_in_t;

  typedef struct packed {
    logic [BIDX_W-1:0] byte_index;
    logic [BYTE_W-1:0] byte_value;
    logic              last_byte;
    logic              out_of_range;
  } byte_out_t;

  // one classified signal write, data and mask already aligned to the byte grid
  typedef struct packed {
    logic [SPAN_W-1:0] data;
    logic [SPAN_W-1:0] mask;
    logic [BASE_W-1:0] base;
    logic              big;
    logic [NB_W-1:0]   nbytes;
  } desc_t;

endpackage

// ===== rtl/core/pdu_signal_bit_packer.sv =====
// signal bit packer top level: front end, descriptor queue, frame buffer back end
// a start passes the queue entry, descriptor, write stage and result registers; one beat per
// cycle while a signal of n bytes (1 to 9) runs, one frame buffer read-modify-write per byte;
// the next waits for the last byte; a two-deep queue holds further signals, busy when full
// reset clears the frame buffer at once through per-byte valid bits, no sweep needed
// results are strobed for one cycle and cannot be held off
module pdu_signal_bit_packer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  pdusbp_pkg::sig_in_t   sig_i,
  output logic                  result_strobe_o,
  output pdusbp_pkg::byte_out_t result_o
);

  pdusbp_pkg::desc_t front_desc;
  pdusbp_pkg::desc_t head_desc;
  logic              q_full, q_valid, q_pop;

  pdusbp_front u_front (
    .sig_i  (sig_i),
    .desc_o (front_desc)
  );

  pdusbp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (start && !q_full),
    .din_i   (front_desc),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .dout_o  (head_desc)
  );

  pdusbp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_desc_i        (head_desc),
    .q_pop_o         (q_pop),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o)
  );

  assign busy = q_full;

endmodule

// ===== rtl/core/pdusbp_front.sv =====
// front end: masks and aligns a signal and works out its byte span
module pdusbp_front (
  input  pdusbp_pkg::sig_in_t sig_i,
  output pdusbp_pkg::desc_t   desc_o
);

  logic [pdusbp_pkg::SIZE_W-1:0] size_sat;
  logic [pdusbp_pkg::VAL_W-1:0]  vmask;
  logic [pdusbp_pkg::OFF_W-1:0]  off;
  logic [pdusbp_pkg::SIZE_W-1:0] nb_sum;
  logic [pdusbp_pkg::NB_W-1:0]   nb;

  always_comb begin
    size_sat = (sig_i.bit_size > pdusbp_pkg::MAX_SIZE) ? pdusbp_pkg::MAX_SIZE : sig_i.bit_size;
    if (size_sat == pdusbp_pkg::MAX_SIZE) begin
      vmask = '1;
    end else begin
      vmask = (pdusbp_pkg::VAL_W'(1) << size_sat) - pdusbp_pkg::VAL_W'(1);
    end
    off    = sig_i.bit_position[pdusbp_pkg::OFF_W-1:0];
    nb_sum = {4'b0, off} + size_sat + 7'd7;
    nb     = nb_sum[pdusbp_pkg::SIZE_W-1:pdusbp_pkg::OFF_W];
    // a zero-size signal still touches its first byte
    if (nb == '0) begin
      nb = pdusbp_pkg::NB_W'(1);
    end

    desc_o.data   = {8'b0, sig_i.signal_value & vmask} << off;
    desc_o.mask   = {8'b0, vmask} << off;
    desc_o.base   = sig_i.bit_position[pdusbp_pkg::POS_W-1:pdusbp_pkg::OFF_W];
    desc_o.big    = sig_i.big_endian;
    desc_o.nbytes = nb;
  end

endmodule

// ===== rtl/core/pdusbp_queue.sv =====
// two-entry descriptor queue between front and back end
module pdusbp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pdusbp_pkg::desc_t din_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output pdusbp_pkg::desc_t dout_o
);

  pdusbp_pkg::desc_t                 entry_q [pdusbp_pkg::QUEUE_DEPTH];
  logic [pdusbp_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [pdusbp_pkg::QCNT_W-1:0]     cnt_q;

  assign full_o  = (cnt_q == pdusbp_pkg::QCNT_W'(pdusbp_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign dout_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= din_i;
    end
  end

endmodule

// ===== rtl/core/pdusbp_back.sv =====
// back end: per-byte read-modify-write of the frame buffer and result output
module pdusbp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  pdusbp_pkg::desc_t     q_desc_i,
  output logic                  q_pop_o,
  output logic                  result_strobe_o,
  output pdusbp_pkg::byte_out_t result_o
);

  logic [pdusbp_pkg::BYTE_W-1:0] mem [pdusbp_pkg::FRAME_BYTES];
  logic [pdusbp_pkg::FRAME_BYTES-1:0] vld_q;

  logic                            act_q;
  pdusbp_pkg::desc_t               cur_q;
  logic [pdusbp_pkg::NB_W-1:0]     k_q;

  logic                            w_vld_q, w_oor_q, w_last_q;
  logic [pdusbp_pkg::IDX_W-1:0]    w_addr_q;
  logic [pdusbp_pkg::BIDX_W-1:0]   w_bidx_q;
  logic [pdusbp_pkg::BYTE_W-1:0]   w_data_q, w_mask_q;
  logic [pdusbp_pkg::BYTE_W-1:0]   rd_q;
  logic                            rd_vld_q;

  logic                            strobe_q;
  pdusbp_pkg::byte_out_t           res_q;

  logic [pdusbp_pkg::CALC_W-1:0]   idx_c;
  logic                            oor_c;
  logic                            last_c;
  logic [pdusbp_pkg::BYTE_W-1:0]   old_c, nv_c;

  always_comb begin
    if (cur_q.big) begin
      idx_c = {4'b0, cur_q.base} - {6'b0, k_q};
    end else begin
      idx_c = {4'b0, cur_q.base} + {6'b0, k_q};
    end
    // negative index shows as the sign bit of the wide sum
    oor_c  = idx_c[pdusbp_pkg::CALC_W-1] ||
             (idx_c >= pdusbp_pkg::CALC_W'(pdusbp_pkg::FRAME_BYTES));
    last_c = (k_q == cur_q.nbytes - 1'b1);
    old_c  = rd_vld_q ? rd_q : '0;
    nv_c   = (old_c & ~w_mask_q) | (w_data_q & w_mask_q);
  end

  // next descriptor loads while the last byte of the previous one writes back
  assign q_pop_o = q_valid_i && !act_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= 1'b0;
      k_q      <= '0;
      w_vld_q  <= 1'b0;
      strobe_q <= 1'b0;
      vld_q    <= '0;
    end else begin
      if (q_pop_o) begin
        act_q <= 1'b1;
        k_q   <= '0;
      end else if (act_q) begin
        k_q <= k_q + 1'b1;
        if (last_c) begin
          act_q <= 1'b0;
        end
      end
      w_vld_q  <= act_q;
      strobe_q <= w_vld_q;
      if (w_vld_q && !w_oor_q) begin
        vld_q[w_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_desc_i;
    end
    w_addr_q <= idx_c[pdusbp_pkg::IDX_W-1:0];
    w_bidx_q <= idx_c[pdusbp_pkg::BIDX_W-1:0];
    w_oor_q  <= oor_c;
    w_last_q <= last_c;
    w_data_q <= cur_q.data[{k_q, 3'b000} +: pdusbp_pkg::BYTE_W];
    w_mask_q <= cur_q.mask[{k_q, 3'b000} +: pdusbp_pkg::BYTE_W];
    rd_q     <= mem[idx_c[pdusbp_pkg::IDX_W-1:0]];
    rd_vld_q <= vld_q[idx_c[pdusbp_pkg::IDX_W-1:0]];
    if (w_vld_q && !w_oor_q) begin
      mem[w_addr_q] <= nv_c;
    end
    res_q.byte_index   <= w_bidx_q;
    res_q.byte_value   <= w_oor_q ? '0 : nv_c;
    res_q.last_byte    <= w_last_q;
    res_q.out_of_range <= w_oor_q;
  end

  assign result_strobe_o = strobe_q;
  assign result_o        = res_q;

`ifndef NO_ASSERTIONS
  a_k_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |-> (k_q < cur_q.nbytes))
    else $error("byte counter ran past the signal span");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q && last_c |=> !act_q && w_vld_q && w_last_q)
    else $error("last byte did not close the signal");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_vld_q && w_oor_q |=> result_strobe_o && result_o.out_of_range &&
                           (result_o.byte_value == '0))
    else $error("out of range beat carries data");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> act_q && (k_q == '0))
    else $error("descriptor load did not start at byte zero");
`endif

endmodule

// ===== bench/pdu_signal_bit_packer_tb.sv =====
// testbench for the signal bit packer: directed and random signal writes against a frame model
`timescale 1ns / 100ps

module pdu_signal_bit_packer_tb;
  import pdusbp_pkg::*;

  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 16;

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start  = 1'b0;
  logic      busy;
  sig_in_t   sig_i  = '0;
  logic      result_strobe_o;
  byte_out_t result_o;

  logic [BYTE_W-1:0] frame_shadow [FRAME_BYTES];
  byte_out_t         expected_bytes [$];
  int unsigned       error_count  = 0;
  int unsigned       stall_cycles = 0;

  pdu_signal_bit_packer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .sig_i           (sig_i),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic sig_in_t make_signal(input int pos, input int size, input bit big,
                                          input logic [VAL_W-1:0] val);
    sig_in_t s;
    s.bit_position = POS_W'(pos);
    s.bit_size     = SIZE_W'(size);
    s.big_endian   = big;
    s.signal_value = val;
    return s;
  endfunction

  // writes one signal into the shadow frame and queues the bytes it touches
  task automatic merge_signal(input sig_in_t s);
    int                size;
    int                off;
    int                base;
    int                nbytes;
    int                idx;
    int                lo;
    int                hi;
    int                span_end;
    logic [VAL_W-1:0]  v;
    logic [BYTE_W-1:0] bmask;
    logic [BYTE_W-1:0] data;
    logic [IDX_W-1:0]  addr;
    byte_out_t         b;
    size = (s.bit_size > MAX_SIZE) ? 64 : int'(s.bit_size);
    v = (size >= 64) ? s.signal_value : s.signal_value & ((64'd1 << size) - 64'd1);
    off = int'(s.bit_position[OFF_W-1:0]);
    base = int'(s.bit_position >> OFF_W);
    nbytes = (off + size + 7) / 8;
    if (nbytes == 0) nbytes = 1;
    for (int k = 0; k < nbytes; k++) begin
      idx = s.big_endian ? base - k : base + k;
      lo = (k == 0) ? off : 0;
      span_end = off + size - 8 * k;
      hi = (span_end > 8) ? 8 : span_end;
      if (hi < lo) hi = lo;
      bmask = BYTE_W'(((1 << (hi - lo)) - 1) << lo);
      data = (k == 0) ? BYTE_W'(v << off) : BYTE_W'(v >> (8 * k - off));
      b.byte_index = BIDX_W'(idx);
      b.last_byte = (k == nbytes - 1);
      if (idx < 0 || idx >= int'(FRAME_BYTES)) begin
        b.byte_value   = '0;
        b.out_of_range = 1'b1;
      end else begin
        addr = IDX_W'(idx);
        frame_shadow[addr] = (frame_shadow[addr] & ~bmask) | (data & bmask);
        b.byte_value   = frame_shadow[addr];
        b.out_of_range = 1'b0;
      end
      expected_bytes.push_back(b);
    end
  endtask

  // start stays high across back-to-back beats, lowered only by idle_gap or wait_drain
  task automatic send_beat(input sig_in_t s);
    start <= 1'b1;
    sig_i <= s;
    do @(posedge clk_i); while (busy);
    merge_signal(s);
  endtask

  task automatic idle_gap(input int pct);
    if (pct > 0 && $urandom_range(99) < pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < pct);
    end
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic sig_in_t random_signal();
    sig_in_t s;
    int      r;
    r = $urandom_range(99);
    // half the writes land in the low part of the frame so they overlap and merge
    s.bit_position = ($urandom_range(1) != 0) ? POS_W'($urandom_range(127))
                                              : POS_W'($urandom_range(511));
    if (r < 6)       s.bit_size = '0;
    else if (r < 12) s.bit_size = SIZE_W'($urandom_range(127, 65));
    else if (r < 20) s.bit_size = MAX_SIZE;
    else             s.bit_size = SIZE_W'($urandom_range(64, 1));
    s.big_endian = 1'($urandom_range(1));
    s.signal_value = ($urandom_range(15) == 0) ? '1 : {$urandom, $urandom};
    return s;
  endfunction

  task automatic test_field_extremes();
    send_beat(make_signal(0, 1, 1'b0, '1));
    send_beat(make_signal(0, 64, 1'b0, '1));
    send_beat(make_signal(0, 64, 1'b0, '0));
    send_beat(make_signal(511, 1, 1'b0, 64'd1));
    send_beat(make_signal(511, 64, 1'b0, '1));
    send_beat(make_signal(511, 64, 1'b1, 64'hA5A5_5A5A_F00F_0FF0));
    send_beat(make_signal(200, 64, 1'b1, 64'h8000_0000_0000_0001));
  endtask

  // indices that run past either end of the frame
  task automatic test_out_of_frame();
    send_beat(make_signal(0, 64, 1'b1, 64'h0123_4567_89AB_CDEF));
    send_beat(make_signal(7, 64, 1'b1, '1));
    send_beat(make_signal(505, 16, 1'b0, 64'hFFFF));
  endtask

  task automatic test_special_sizes();
    send_beat(make_signal(13, 0, 1'b0, '1));
    send_beat(make_signal(511, 0, 1'b1, '1));
    send_beat(make_signal(100, 127, 1'b0, 64'hDEAD_BEEF_CAFE_F00D));
    send_beat(make_signal(300, 65, 1'b1, '1));
    send_beat(make_signal(16, 8, 1'b0, 64'h1_5A));
  endtask

  // partial-byte writes must keep the neighboring bits
  task automatic test_neighbor_merge();
    send_beat(make_signal(3, 4, 1'b0, '1));
    send_beat(make_signal(8, 2, 1'b0, 64'h2));
    send_beat(make_signal(1, 1, 1'b0, '1));
    send_beat(make_signal(4, 2, 1'b0, '0));
    send_beat(make_signal(20, 12, 1'b1, 64'hABC));
  endtask

  task automatic test_random_stream(input int count, input int pct);
    for (int i = 0; i < count; i++) begin
      send_beat(random_signal());
      idle_gap(pct);
    end
  endtask

  always @(posedge clk_i) begin
    byte_out_t want;
    if (rst_ni && result_strobe_o) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected result beat: byte_index %0d byte_value %0h",
               result_o.byte_index, result_o.byte_value);
        error_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (result_o.byte_index !== want.byte_index) begin
          $error("byte_index: expected %0d, got %0d", want.byte_index, result_o.byte_index);
          error_count++;
        end
        if (result_o.byte_value !== want.byte_value) begin
          $error("byte_value: expected %0h, got %0h", want.byte_value, result_o.byte_value);
          error_count++;
        end
        if (result_o.last_byte !== want.last_byte) begin
          $error("last_byte: expected %0b, got %0b", want.last_byte, result_o.last_byte);
          error_count++;
        end
        if (result_o.out_of_range !== want.out_of_range) begin
          $error("out_of_range: expected %0b, got %0b", want.out_of_range,
                 result_o.out_of_range);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_strobe_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    foreach (frame_shadow[i]) frame_shadow[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_out_of_frame();
    test_special_sizes();
    test_neighbor_merge();
    wait_drain();
    test_random_stream(160, 0);
    wait_drain();
    test_random_stream(150, 85);
    wait_drain();
    test_random_stream(150, 19);
    wait_drain();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/pdusbp_pkg.sv
rtl/core/pdusbp_front.sv
rtl/core/pdusbp_queue.sv
rtl/core/pdusbp_back.sv
rtl/core/pdu_signal_bit_packer.sv
bench/pdu_signal_bit_packer_tb.sv
